// ===== rtl/frc_pkg.sv =====
// Shared types and constants for the fraction reduce-and-compare block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package frc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GCD,
    ST_DIV_INIT,
    ST_DIV,
    ST_STORE,
    ST_NEXT,
    ST_OUT
  } frc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture an input transfer
    logic gcd_init;  // load the GCD unit from the selected fraction
    logic gcd_step;  // one binary GCD iteration
    logic gcd_fin;   // latch the divisor
    logic div_init;  // start dividing the selected part by the divisor
    logic div_step;  // one restoring division step
    logic store;     // write the quotient back to the selected part
    logic out_load;  // move the result into the output register
    logic frac;      // 0: first fraction, 1: second fraction
    logic part;      // 0: numerator, 1: denominator
  } frc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;      // selected fraction has a part that is zero or negative
    logic gcd_eq;    // GCD operands have met
    logic div_last;  // current division step is the last one
    logic out_busy;  // output register holds a result that is not taken
  } frc_status_t;

endpackage

`default_nettype wire

// ===== rtl/fraction_reduce_and_compare.sv =====
// Top level of the fraction reduce-and-compare block.
// Joins frc_ctrl and frc_dpath and packs the stream channels; uses frc_pkg.
//
// Usage: one input transfer on in_* carries two fractions (numerator and
// denominator each, two's complement). Each fraction whose parts are both
// positive is divided by their greatest common divisor; any other fraction is
// returned unchanged. One output transfer on out_* carries both fractions and
// a flag that is set when the returned parts are identical.
// Timing: one item at a time. After acceptance each fraction is checked and,
// when it is reduced, runs the binary GCD loop and then two divisions
// (numerator, then denominator) in the shared restoring divider, which makes
// one quotient bit per cycle; the output load ends the item.
// The output register frees the input side: in_tready rises again as soon as
// a result sits in it. If the receiver stalls, the next result waits in the
// sequencer until the output register is taken.
// Reset (rst_n low, synchronous) returns to idle and drops out_tvalid.
`default_nettype none

module fraction_reduce_and_compare #(
  parameter int unsigned VALUE_WIDTH = frc_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned IN_W  = ((4 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((4 * VALUE_WIDTH + 8) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: first_numerator, first_denominator, second_numerator,
  // second_denominator, zero padding.
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // Fields from bit 0: reduced_first_numerator, reduced_first_denominator,
  // reduced_second_numerator, reduced_second_denominator, fractions_equal,
  // zero padding.
  output logic [OUT_W-1:0]      out_tdata
);

  localparam int unsigned W = VALUE_WIDTH;

  frc_pkg::frc_cmd_t    cmd;
  frc_pkg::frc_status_t status;
  logic [W-1:0]         o_n1, o_d1, o_n2, o_d2;
  logic                 o_eq;

  frc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  frc_dpath #(.VALUE_WIDTH(W)) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_n1      (in_tdata[W-1:0]),
    .in_d1      (in_tdata[2*W-1:W]),
    .in_n2      (in_tdata[3*W-1:2*W]),
    .in_d2      (in_tdata[4*W-1:3*W]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_n1     (o_n1),
    .out_d1     (o_d1),
    .out_n2     (o_n2),
    .out_d2     (o_d2),
    .out_eq     (o_eq)
  );

  assign out_tdata = OUT_W'({o_eq, o_d2, o_n2, o_d1, o_n1});

endmodule

`default_nettype wire

// ===== rtl/frc_ctrl.sv =====
// Sequencer of the fraction reduce-and-compare block.
// For each fraction: check, then GCD and two divisions unless skipped; uses frc_pkg.
`default_nettype none

module frc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire frc_pkg::frc_status_t status,
  output frc_pkg::frc_cmd_t        cmd
);

  frc_pkg::frc_state_t state_r, state_nxt;
  logic                frac_r, frac_nxt;
  logic                part_r, part_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frc_pkg::ST_IDLE;
      frac_r  <= 1'b0;
      part_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      frac_r  <= frac_nxt;
      part_r  <= part_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    frac_nxt  = frac_r;
    part_nxt  = part_r;
    case (state_r)
      frc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = frc_pkg::ST_CHECK;
          frac_nxt  = 1'b0;
        end
      end
      frc_pkg::ST_CHECK: begin
        state_nxt = status.skip ? frc_pkg::ST_NEXT : frc_pkg::ST_GCD;
      end
      frc_pkg::ST_GCD: begin
        if (status.gcd_eq) begin
          state_nxt = frc_pkg::ST_DIV_INIT;
          part_nxt  = 1'b0;
        end
      end
      frc_pkg::ST_DIV_INIT: state_nxt = frc_pkg::ST_DIV;
      frc_pkg::ST_DIV: begin
        if (status.div_last) state_nxt = frc_pkg::ST_STORE;
      end
      frc_pkg::ST_STORE: begin
        if (!part_r) begin
          part_nxt  = 1'b1;
          state_nxt = frc_pkg::ST_DIV_INIT;
        end else begin
          state_nxt = frc_pkg::ST_NEXT;
        end
      end
      frc_pkg::ST_NEXT: begin
        if (!frac_r) begin
          frac_nxt  = 1'b1;
          state_nxt = frc_pkg::ST_CHECK;
        end else begin
          state_nxt = frc_pkg::ST_OUT;
        end
      end
      frc_pkg::ST_OUT: begin
        if (!status.out_busy) state_nxt = frc_pkg::ST_IDLE;
      end
      default: state_nxt = frc_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    cmd.frac  = frac_r;
    cmd.part  = part_r;
    in_tready = 1'b0;
    case (state_r)
      frc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      frc_pkg::ST_CHECK:    cmd.gcd_init = !status.skip;
      frc_pkg::ST_GCD: begin
        cmd.gcd_fin  = status.gcd_eq;
        cmd.gcd_step = !status.gcd_eq;
      end
      frc_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
      frc_pkg::ST_DIV:      cmd.div_step = 1'b1;
      frc_pkg::ST_STORE:    cmd.store    = 1'b1;
      frc_pkg::ST_OUT:      cmd.out_load = !status.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/frc_dpath.sv =====
// Datapath of the fraction reduce-and-compare block: work registers, a binary
// GCD unit, a restoring divider and the output register. Uses frc_pkg.
`default_nettype none

module frc_dpath #(
  parameter int unsigned VALUE_WIDTH = frc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire frc_pkg::frc_cmd_t      cmd,
  output frc_pkg::frc_status_t        status,
  input  wire logic [VALUE_WIDTH-1:0] in_n1,
  input  wire logic [VALUE_WIDTH-1:0] in_d1,
  input  wire logic [VALUE_WIDTH-1:0] in_n2,
  input  wire logic [VALUE_WIDTH-1:0] in_d2,
  input  wire logic                   out_tready,
  output logic                        out_tvalid,
  output logic [VALUE_WIDTH-1:0]      out_n1,
  output logic [VALUE_WIDTH-1:0]      out_d1,
  output logic [VALUE_WIDTH-1:0]      out_n2,
  output logic [VALUE_WIDTH-1:0]      out_d2,
  output logic                        out_eq
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned KW = $clog2(W + 1);
  localparam int unsigned CW = $clog2(W);

  // Work registers, one numerator and one denominator per fraction.
  logic [W-1:0] num_r [2];
  logic [W-1:0] den_r [2];

  logic [W-1:0]  a_r, b_r, g_r;
  logic [KW-1:0] k_r;
  logic [W-1:0]  rem_r, dvd_r;
  logic [CW-1:0] cnt_r;
  logic          out_valid_r;

  logic [W-1:0] sel_num, sel_den, sel_part;
  logic [W-1:0] a_nxt, b_nxt;
  logic [KW-1:0] k_nxt;
  logic [W:0]   rem_sh, rem_sub;
  logic         q_bit;

  assign sel_num  = num_r[cmd.frac];
  assign sel_den  = den_r[cmd.frac];
  assign sel_part = cmd.part ? sel_den : sel_num;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    k_nxt = k_r;
    if (!a_r[0] && !b_r[0]) begin
      a_nxt = a_r >> 1;
      b_nxt = b_r >> 1;
      k_nxt = k_r + KW'(1);
    end else if (!a_r[0]) begin
      a_nxt = a_r >> 1;
    end else if (!b_r[0]) begin
      b_nxt = b_r >> 1;
    end else if (a_r > b_r) begin
      a_nxt = (a_r - b_r) >> 1;
    end else begin
      b_nxt = (b_r - a_r) >> 1;
    end
  end

  assign rem_sh  = {rem_r, dvd_r[W-1]};
  assign rem_sub = rem_sh - {1'b0, g_r};
  assign q_bit   = !rem_sub[W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r[0] <= in_n1;
      den_r[0] <= in_d1;
      num_r[1] <= in_n2;
      den_r[1] <= in_d2;
    end else if (cmd.store) begin
      if (cmd.part) den_r[cmd.frac] <= dvd_r;
      else          num_r[cmd.frac] <= dvd_r;
    end
    if (cmd.gcd_init) begin
      a_r <= sel_num;
      b_r <= sel_den;
      k_r <= '0;
    end else if (cmd.gcd_step) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      k_r <= k_nxt;
    end
    if (cmd.gcd_fin) g_r <= a_r << k_r;
    if (cmd.div_init) begin
      rem_r <= '0;
      dvd_r <= sel_part;
      cnt_r <= CW'(W - 1);
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_sub[W-1:0] : rem_sh[W-1:0];
      dvd_r <= {dvd_r[W-2:0], q_bit};
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd.out_load) begin
      out_n1 <= num_r[0];
      out_d1 <= den_r[0];
      out_n2 <= num_r[1];
      out_d2 <= den_r[1];
      out_eq <= (num_r[0] == num_r[1]) && (den_r[0] == den_r[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  // A fraction is reduced only when both parts are strictly positive.
  assign status.skip     = sel_num[W-1] || (sel_num == '0) ||
                           sel_den[W-1] || (sel_den == '0);
  assign status.gcd_eq   = (a_r == b_r);
  assign status.div_last = (cnt_r == '0);
  assign status.out_busy = out_valid_r && !out_tready;

  // The GCD operands stay nonzero, so the loop always ends with a == b.
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gcd_step |=> (a_r != '0) && (b_r != '0))
    else $error("GCD operand reached zero");

  a_div_by_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (g_r != '0))
    else $error("division by a zero divisor");

  // Both parts are multiples of the divisor, so nothing is left over.
  a_exact_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> (rem_r == '0))
    else $error("reduction left a nonzero remainder");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_tready))
    else $error("output register overwritten before its transfer");

endmodule

`default_nettype wire
